>>> src/kcl_pkg.sv
package kcl_pkg;

  localparam int unsigned BUF_LEN   = 10;
  localparam int unsigned CODE_LEN  = 4;
  localparam int unsigned KEY_W     = 4;
  localparam int unsigned POS_W     = 4;

  localparam logic [KEY_W-1:0] KEY_ZERO = 4'd0;
  localparam logic [KEY_W-1:0] KEY_ONE  = 4'd1;
  localparam logic [KEY_W-1:0] KEY_STAR = 4'd10;
  localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;

  // Position of the last key of a relay command and of a code change
  localparam logic [POS_W-1:0] POS_RELAY_END = 4'd6;
  localparam logic [POS_W-1:0] POS_CHG_END   = 4'd9;
  localparam logic [POS_W-1:0] POS_FIRST     = 4'd0;

  typedef enum logic [1:0] {
    SCAN_NONE  = 2'd0,
    SCAN_ERROR = 2'd1,
    SCAN_KEY   = 2'd2,
    SCAN_RSVD  = 2'd3
  } scan_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_OFF     = 3'd1,
    EV_ON      = 3'd2,
    EV_CHANGED = 3'd3,
    EV_INVALID = 3'd4
  } ev_t;

  typedef struct packed {
    logic [1:0]       scan_status;
    logic [KEY_W-1:0] key_code;
  } item_t;

  typedef struct packed {
    ev_t  event_res;
    logic relay_on;
  } res_t;

endpackage

>>> src/keypad_code_lock.sv
// Keypad code lock: each input transaction is one keypad scan (scan_status
// in in_tuser, key_code in in_tdata) and yields exactly one result
// transaction carrying an event code and the relay drive state after that
// scan. A key counts only on the first scan after a "no key" scan. Seven
// keys forming code*0# or code*1# switch the relay off or on; ten keys
// forming code*NNNN# load NNNN as the new four-key code (reset code 0000);
// a ten-key sequence that matches nothing is reported invalid and dropped.
// Throughput is one transaction per clock while the result side keeps up;
// a scan passes the input register, then the result register, with the
// whole command decode done by parallel compares between them. Output
// backpressure stalls the input side only once both registers are full.
module keypad_code_lock (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] key_code, [7:4] zero
  input  logic [1:0] in_tuser,   // [1:0] scan_status
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [2:0] event_res, [3] relay_on, [7:4] zero
);
  import kcl_pkg::*;

  logic  in_vld_r;
  item_t in_item_r;
  logic  out_vld_r;
  res_t  out_res_r;
  logic  advance;
  res_t  eng_res;

  // Move the held scan into the result register when that slot is free or being taken
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  kcl_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (in_item_r),
    .res   (eng_res)
  );

  // Input register: hold a scan until the engine takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.scan_status <= in_tuser;
      in_item_r.key_code    <= in_tdata[3:0];
    end
  end

  // Result register: hold until the downstream side takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= eng_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_res_r.relay_on, out_res_r.event_res};

endmodule

>>> src/kcl_engine.sv
module kcl_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  kcl_pkg::item_t item,
  output kcl_pkg::res_t  res
);
  import kcl_pkg::*;

  logic                 last_rel_r, last_rel_nxt;
  logic [POS_W-1:0]     key_pos_r, key_pos_nxt;
  logic [KEY_W-1:0]     code_r [CODE_LEN];
  logic [KEY_W-1:0]     code_nxt [CODE_LEN];
  logic                 relay_r, relay_nxt;
  logic [KEY_W-1:0]     buf_r [BUF_LEN];

  logic                 key_acc;
  logic [POS_W-1:0]     pos;
  logic                 prefix_ok;
  ev_t                  ev;

  assign key_acc = fire && (item.scan_status == SCAN_KEY) && last_rel_r;
  assign pos     = (key_pos_r >= POS_W'(BUF_LEN)) ? POS_FIRST : key_pos_r;

  // Stored entries only: the prefix is checked at the seventh or tenth key
  assign prefix_ok = (buf_r[0] == code_r[0]) && (buf_r[1] == code_r[1]) &&
                     (buf_r[2] == code_r[2]) && (buf_r[3] == code_r[3]) &&
                     (buf_r[4] == KEY_STAR);

  always_comb begin
    last_rel_nxt = fire ? (item.scan_status == SCAN_NONE) : last_rel_r;
    key_pos_nxt  = key_pos_r;
    relay_nxt    = relay_r;
    ev           = EV_NONE;
    for (int i = 0; i < CODE_LEN; i++) begin
      code_nxt[i] = code_r[i];
    end
    if (key_acc) begin
      if (pos == POS_RELAY_END && prefix_ok && buf_r[5] == KEY_ZERO &&
          item.key_code == KEY_HASH) begin
        relay_nxt   = 1'b0;
        ev          = EV_OFF;
        key_pos_nxt = POS_FIRST;
      end else if (pos == POS_RELAY_END && prefix_ok && buf_r[5] == KEY_ONE &&
                   item.key_code == KEY_HASH) begin
        relay_nxt   = 1'b1;
        ev          = EV_ON;
        key_pos_nxt = POS_FIRST;
      end else if (pos == POS_CHG_END && prefix_ok && item.key_code == KEY_HASH) begin
        code_nxt[0] = buf_r[5];
        code_nxt[1] = buf_r[6];
        code_nxt[2] = buf_r[7];
        code_nxt[3] = buf_r[8];
        ev          = EV_CHANGED;
        key_pos_nxt = POS_FIRST;
      end else if (pos == POS_CHG_END) begin
        ev          = EV_INVALID;
        key_pos_nxt = POS_FIRST;
      end else begin
        key_pos_nxt = pos + POS_W'(1);
      end
    end
  end

  assign res.event_res = ev;
  assign res.relay_on  = relay_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rel_r <= 1'b1;
      key_pos_r  <= POS_FIRST;
      relay_r    <= 1'b0;
      for (int i = 0; i < CODE_LEN; i++) begin
        code_r[i] <= '0;
      end
    end else begin
      last_rel_r <= last_rel_nxt;
      key_pos_r  <= key_pos_nxt;
      relay_r    <= relay_nxt;
      for (int i = 0; i < CODE_LEN; i++) begin
        code_r[i] <= code_nxt[i];
      end
    end
  end

  // Key buffer has no reset; only entries written in this sequence are compared
  always_ff @(posedge clk) begin
    if (key_acc) begin
      buf_r[pos] <= item.key_code;
    end
  end

endmodule

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kcl_pkg::*;

  // Kinds of keypad traffic produced by the random part of the run
  typedef enum logic [2:0] {
    SEQ_RELAY,
    SEQ_CHANGE,
    SEQ_INVALID,
    SEQ_NEAR_MISS,
    SEQ_NOISE
  } seq_kind_t;

  localparam int unsigned ITEMS_PER_PHASE = 400;
  localparam int unsigned DRAIN_CYCLES    = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;   // [3:0] key_code, [7:4] zero
  logic [1:0] in_tuser = '0;   // [1:0] scan_status
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;       // [2:0] event_res, [3] relay_on, [7:4] zero

  // Lock state as the keypad logic should see it
  logic             key_released = 1'b1;
  logic [KEY_W-1:0] key_buf [BUF_LEN] = '{default: '0};
  logic [POS_W-1:0] key_pos = POS_FIRST;
  logic [KEY_W-1:0] lock_code [CODE_LEN] = '{default: '0};
  logic             relay = 1'b0;

  res_t        lock_results_q[$];
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned scans_sent = 0;
  int unsigned mismatches = 0;

  keypad_code_lock u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the lock state by one accepted scan and queue the result it owes.
  function automatic void predict_lock(scan_t status, logic [KEY_W-1:0] key);
    logic             take;
    logic             head_ok;
    logic [POS_W-1:0] slot;
    ev_t              ev;
    ev   = EV_NONE;
    take = (status == SCAN_KEY) && key_released;
    // Edge detection runs on every scan, whether a key is taken or not
    key_released = (status == SCAN_NONE);
    if (take) begin
      slot = (key_pos >= BUF_LEN) ? POS_FIRST : key_pos;
      key_buf[slot] = key;
      head_ok = key_buf[0] == lock_code[0] && key_buf[1] == lock_code[1] &&
                key_buf[2] == lock_code[2] && key_buf[3] == lock_code[3] &&
                key_buf[4] == KEY_STAR;
      if (slot == POS_RELAY_END && head_ok && key_buf[5] == KEY_ZERO &&
          key_buf[6] == KEY_HASH) begin
        relay = 1'b0;
        ev    = EV_OFF;
        slot  = POS_FIRST;
      end else if (slot == POS_RELAY_END && head_ok && key_buf[5] == KEY_ONE &&
                   key_buf[6] == KEY_HASH) begin
        relay = 1'b1;
        ev    = EV_ON;
        slot  = POS_FIRST;
      end else if (slot == POS_CHG_END && head_ok && key_buf[9] == KEY_HASH) begin
        for (int i = 0; i < CODE_LEN; i++) lock_code[i] = key_buf[5 + i];
        ev   = EV_CHANGED;
        slot = POS_FIRST;
      end else if (slot == POS_CHG_END) begin
        // Ten keys that match nothing: drop the whole sequence
        ev   = EV_INVALID;
        slot = POS_FIRST;
      end else begin
        slot = slot + 1'b1;
      end
      key_pos = slot;
    end
    lock_results_q.push_back('{event_res: ev, relay_on: relay});
  endfunction

  // Send one scan transaction; hold valid until it is taken, then predict.
  task automatic send_scan(scan_t status, logic [KEY_W-1:0] key);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= status;
    in_tdata  <= {4'b0000, key};
    do @(posedge clk); while (!in_tready);
    scans_sent++;
    predict_lock(status, key);
  endtask

  // One key press: the key, optional bounce or scan trouble, then a release.
  task automatic press_key(logic [KEY_W-1:0] key, bit noisy);
    int unsigned extra;
    send_scan(SCAN_KEY, key);
    extra = noisy ? $urandom_range(2) : 0;
    repeat (extra) begin
      case ($urandom_range(2))
        0:       send_scan(SCAN_KEY, 4'($urandom_range(15)));
        1:       send_scan(SCAN_ERROR, 4'($urandom_range(15)));
        default: send_scan(SCAN_RSVD, 4'($urandom_range(15)));
      endcase
    end
    send_scan(SCAN_NONE, 4'($urandom_range(15)));
    if (noisy && $urandom_range(7) == 0) send_scan(SCAN_NONE, 4'($urandom_range(15)));
  endtask

  // Hold off new scans until every owed result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (lock_results_q.size() != 0) @(posedge clk);
  endtask

  // Press keys until the buffer position is back at its first slot.
  task automatic align_buffer();
    while (key_pos != POS_FIRST) press_key(4'($urandom_range(15)), 1'b1);
  endtask

  task automatic test_relay_on_with_glitches();
    send_scan(SCAN_KEY, KEY_ZERO);
    send_scan(SCAN_KEY, KEY_ZERO);      // held key, no second press
    send_scan(SCAN_NONE, 4'd0);
    send_scan(SCAN_RSVD, 4'd15);        // reserved status acts as a scan error
    send_scan(SCAN_KEY, 4'd15);         // no release seen, so not taken
    send_scan(SCAN_NONE, 4'd15);
    send_scan(SCAN_KEY, KEY_ZERO);
    send_scan(SCAN_ERROR, 4'd15);
    send_scan(SCAN_NONE, 4'd0);
    press_key(KEY_ZERO, 1'b0);
    press_key(KEY_ZERO, 1'b0);
    press_key(KEY_STAR, 1'b0);
    press_key(KEY_ONE, 1'b0);
    press_key(KEY_HASH, 1'b0);
  endtask

  task automatic test_relay_off();
    for (int i = 0; i < CODE_LEN; i++) press_key(lock_code[i], 1'b0);
    press_key(KEY_STAR, 1'b0);
    press_key(KEY_ZERO, 1'b0);
    press_key(KEY_HASH, 1'b0);
  endtask

  // Well-formed commands with random content, plus invalid sequences, near misses and noise.
  task automatic test_random_traffic(int unsigned gap, int unsigned stall);
    int unsigned      stop_at;
    int unsigned      pick;
    int unsigned      seq_len;
    seq_kind_t        kind;
    logic [KEY_W-1:0] seq [BUF_LEN];
    gap_pct   = gap;
    stall_pct = stall;
    stop_at   = scans_sent + ITEMS_PER_PHASE;
    while (scans_sent < stop_at) begin
      pick = $urandom_range(99);
      kind = pick < 30 ? SEQ_RELAY : pick < 48 ? SEQ_CHANGE : pick < 63 ? SEQ_INVALID :
             pick < 75 ? SEQ_NEAR_MISS : SEQ_NOISE;
      if (kind != SEQ_NOISE) align_buffer();
      for (int i = 0; i < CODE_LEN; i++) seq[i] = lock_code[i];
      seq[4] = KEY_STAR;
      seq_len = BUF_LEN;
      case (kind)
        SEQ_RELAY: begin
          seq[5]  = $urandom_range(1) ? KEY_ONE : KEY_ZERO;
          seq[6]  = KEY_HASH;
          seq_len = POS_RELAY_END + 1;
        end
        SEQ_CHANGE: begin
          // Favor digits so the code stays typical, but allow any key
          for (int i = 5; i < 9; i++)
            seq[i] = $urandom_range(3) == 0 ? 4'($urandom_range(15)) : 4'($urandom_range(9));
          seq[9] = KEY_HASH;
        end
        SEQ_INVALID: begin
          if ($urandom_range(1)) seq[$urandom_range(4)] = 4'($urandom_range(15));
          for (int i = 5; i < BUF_LEN; i++) seq[i] = 4'($urandom_range(15));
          if ($urandom_range(1)) seq[9] = KEY_HASH;
        end
        SEQ_NEAR_MISS: begin
          // Correct head, random tail on a relay command; position runs on
          seq[5]  = 4'($urandom_range(15));
          seq[6]  = 4'($urandom_range(15));
          seq_len = POS_RELAY_END + 1;
        end
        default: begin
          seq_len = 0;
          repeat ($urandom_range(8, 1))
            send_scan(scan_t'($urandom_range(3)), 4'($urandom_range(15)));
        end
      endcase
      for (int i = 0; i < seq_len; i++) press_key(seq[i], $urandom_range(3) == 0);
    end
    drain_results();
  endtask

  // Check each result against the oldest owed one; set receiver stalls.
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (lock_results_q.size() == 0) begin
        $error("unexpected result transaction: out_tdata=0x%02h", out_tdata);
        mismatches++;
      end else begin
        want = lock_results_q.pop_front();
        if (out_tdata[2:0] !== want.event_res) begin
          $error("event_res: expected %0d, got %0d", want.event_res, out_tdata[2:0]);
          mismatches++;
        end
        if (out_tdata[3] !== want.relay_on) begin
          $error("relay_on: expected %0d, got %0d", want.relay_on, out_tdata[3]);
          mismatches++;
        end
        if (out_tdata[7:4] !== 4'b0000) begin
          $error("pad: expected 0, got 0x%0h", out_tdata[7:4]);
          mismatches++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_relay_on_with_glitches();
    test_relay_off();
    drain_results();

    test_random_traffic(0, 0);
    test_random_traffic(85, 0);
    test_random_traffic(0, 85);
    test_random_traffic(16, 16);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lock_results_q.size() != 0) begin
      $error("results never delivered: %0d", lock_results_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
